### design/fcbb_pkg.sv
`default_nettype none

package fcbb_pkg;

    // Fixed field widths of the request and result words.
    localparam int KEY_W    = 48;
    localparam int HANDLE_W = 64;
    localparam int SIZE_W   = 24;
    localparam int STATUS_W = 3;
    localparam int EVN_W    = 7;
    localparam int WORD_W   = 32;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_PRESENT   = 3'd3,
        ST_TOO_LARGE = 3'd4
    } t_status;

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MATCH = 7'b0000010,
        S_LOOK  = 7'b0000100,
        S_HITRD = 7'b0001000,
        S_EVICT = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    ld_req;
        logic    rd_hit;
        logic    cnt_hit;
        logic    cnt_miss;
        logic    cap_found;
        logic    res_we;
        t_status res_status;
        logic    evict;
        logic    insert;
        logic    ld_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_type;
        logic hit;
        logic too_large;
        logic need_evict;
        logic full;
        logic empty;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

### design/fcbb_ram.sv
`default_nettype none

module fcbb_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/fcbb_ctrl.sv
`default_nettype none

module fcbb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fcbb_pkg::t_stat i_stat,
    output fcbb_pkg::t_cmd  o_cmd
);

    import fcbb_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        w_cmd.res_status = ST_MISS;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_cmd.ld_req = 1'b1;
                    n_state      = S_MATCH;
                end
            end
            S_MATCH: begin
                n_state = S_LOOK;
            end
            S_LOOK: begin
                if (!i_stat.req_type) begin
                    if (i_stat.hit) begin
                        w_cmd.rd_hit  = 1'b1;
                        w_cmd.cnt_hit = 1'b1;
                        n_state       = S_HITRD;
                    end else begin
                        w_cmd.cnt_miss   = 1'b1;
                        w_cmd.res_we     = 1'b1;
                        w_cmd.res_status = ST_MISS;
                        n_state          = S_DONE;
                    end
                end else if (i_stat.hit) begin
                    w_cmd.res_we     = 1'b1;
                    w_cmd.res_status = ST_PRESENT;
                    n_state          = S_DONE;
                end else if (i_stat.too_large) begin
                    w_cmd.res_we     = 1'b1;
                    w_cmd.res_status = ST_TOO_LARGE;
                    n_state          = S_DONE;
                end else begin
                    n_state = S_EVICT;
                end
            end
            S_HITRD: begin
                w_cmd.cap_found  = 1'b1;
                w_cmd.res_we     = 1'b1;
                w_cmd.res_status = ST_HIT;
                n_state          = S_DONE;
            end
            S_EVICT: begin
                // Drop the oldest word until the new one fits, then once more if full.
                if (i_stat.need_evict) begin
                    w_cmd.evict = 1'b1;
                end else begin
                    w_cmd.evict = i_stat.full;
                    n_state     = S_WRITE;
                end
            end
            S_WRITE: begin
                w_cmd.insert     = 1'b1;
                w_cmd.res_we     = 1'b1;
                w_cmd.res_status = ST_INSERTED;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    w_cmd.ld_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd   = w_cmd;
    assign o_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

### design/fcbb_dp.sv
`default_nettype none

module fcbb_dp #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [fcbb_pkg::WORD_W-1:0]       i_cfg_capacity_bytes,
    input  logic                              i_req_type,
    input  logic [fcbb_pkg::KEY_W-1:0]        i_key,
    input  logic [fcbb_pkg::HANDLE_W-1:0]     i_object_handle,
    input  logic [fcbb_pkg::SIZE_W-1:0]       i_item_size,
    input  fcbb_pkg::t_cmd                    i_cmd,
    output fcbb_pkg::t_stat                   o_stat,
    input  logic                              i_out_ready,
    output logic                              o_valid,
    output logic [fcbb_pkg::STATUS_W-1:0]     o_status,
    output logic [fcbb_pkg::HANDLE_W-1:0]     o_found_handle,
    output logic [fcbb_pkg::SIZE_W-1:0]       o_found_size,
    output logic [fcbb_pkg::EVN_W-1:0]        o_evicted_now,
    output logic [fcbb_pkg::WORD_W-1:0]       o_bytes_in_use,
    output logic [fcbb_pkg::WORD_W-1:0]       o_hit_total,
    output logic [fcbb_pkg::WORD_W-1:0]       o_miss_total,
    output logic [fcbb_pkg::WORD_W-1:0]       o_evict_total
);

    import fcbb_pkg::*;

    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int RAM_W = HANDLE_W + SIZE_W;

    // Configuration and latched request.
    logic [WORD_W-1:0]   r_cap;
    logic                r_req_type;
    logic [KW-1:0]       r_key;
    logic [HANDLE_W-1:0] r_handle;
    logic [SIZE_W-1:0]   r_size;

    // Key store, valid bits and ring pointers.
    logic [KW-1:0]          r_keys [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [MAX_ENTRIES-1:0] r_vec;
    logic [MAX_ENTRIES-1:0] w_vec;
    logic [AW-1:0]          r_head;
    logic [AW-1:0]          r_tail;
    logic [AW-1:0]          n_tail;
    logic [AW-1:0]          w_head_inc;
    logic [AW-1:0]          w_tail_inc;
    logic [AW-1:0]          w_hit_idx;
    logic [AW-1:0]          w_raddr;
    logic [CW-1:0]          r_count;

    // Totals.
    logic [WORD_W-1:0] r_bytes;
    logic [WORD_W-1:0] r_hits;
    logic [WORD_W-1:0] r_misses;
    logic [WORD_W-1:0] r_evicts;
    logic [EVN_W-1:0]  r_evn;

    // Per-word result.
    t_status             r_res_status;
    logic [HANDLE_W-1:0] r_res_fh;
    logic [SIZE_W-1:0]   r_res_fs;

    // Output register.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [HANDLE_W-1:0] r_out_fh;
    logic [SIZE_W-1:0]   r_out_fs;
    logic [EVN_W-1:0]    r_out_evn;
    logic [WORD_W-1:0]   r_out_bytes;
    logic [WORD_W-1:0]   r_out_hits;
    logic [WORD_W-1:0]   r_out_misses;
    logic [WORD_W-1:0]   r_out_evicts;

    // Handle and size store.
    logic [RAM_W-1:0]    w_rdata;
    logic [HANDLE_W-1:0] w_rd_handle;
    logic [SIZE_W-1:0]   w_rd_size;
    logic [WORD_W-1:0]   w_rd_size_ext;
    logic [WORD_W-1:0]   w_bytes_evict;
    logic [WORD_W:0]     w_need_sum;

    fcbb_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.insert),
        .i_waddr (r_head),
        .i_wdata ({r_handle, r_size}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_handle   = w_rdata[RAM_W-1:SIZE_W];
    assign w_rd_size     = w_rdata[SIZE_W-1:0];
    assign w_rd_size_ext = WORD_W'(w_rd_size);

    // Ring pointer arithmetic with wrap at the table depth.
    assign w_head_inc = (r_head == AW'(MAX_ENTRIES - 1)) ? '0 : r_head + 1'b1;
    assign w_tail_inc = (r_tail == AW'(MAX_ENTRIES - 1)) ? '0 : r_tail + 1'b1;
    assign n_tail     = i_cmd.evict ? w_tail_inc : r_tail;

    // The store normally reads the oldest word so its size is ready for eviction.
    assign w_raddr = i_cmd.rd_hit ? w_hit_idx : n_tail;

    // Parallel key compare against every valid slot.
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_vec[i] = r_valid[i] && (r_keys[i] == r_key);
        end
    end

    // Keys are unique among valid slots, so an OR of indexes encodes the match.
    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (r_vec[i]) begin
                w_hit_idx = w_hit_idx | AW'(i);
            end
        end
    end

    // Fit test and clamped byte release on eviction.
    assign w_need_sum    = {1'b0, r_bytes} + (WORD_W + 1)'(r_size);
    assign w_bytes_evict = (r_bytes >= w_rd_size_ext) ? r_bytes - w_rd_size_ext : '0;

    always_comb begin
        o_stat            = '0;
        o_stat.req_type   = r_req_type;
        o_stat.hit        = |r_vec;
        o_stat.too_large  = WORD_W'(r_size) > r_cap;
        o_stat.need_evict = (r_count != '0) && (w_need_sum > {1'b0, r_cap});
        o_stat.full       = (r_count == CW'(MAX_ENTRIES));
        o_stat.empty      = (r_count == '0);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // Byte budget register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= '0;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_capacity_bytes;
        end
    end

    // Request latch, key store and match register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_req_type <= i_req_type;
            r_key      <= i_key[KW-1:0];
            r_handle   <= i_object_handle;
            r_size     <= i_item_size;
        end
        if (i_cmd.insert) begin
            r_keys[r_head] <= r_key;
        end
        r_vec <= w_vec;
    end

    // Directory state and totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_bytes  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else begin
            r_tail <= n_tail;
            if (i_cmd.evict) begin
                r_valid[r_tail] <= 1'b0;
                r_count         <= r_count - 1'b1;
                r_bytes         <= w_bytes_evict;
                if (r_evicts != '1) begin
                    r_evicts <= r_evicts + 1'b1;
                end
            end
            if (i_cmd.insert) begin
                r_valid[r_head] <= 1'b1;
                r_head          <= w_head_inc;
                r_count         <= r_count + 1'b1;
                r_bytes         <= r_bytes + WORD_W'(r_size);
            end
            if (i_cmd.cnt_hit && r_hits != '1) begin
                r_hits <= r_hits + 1'b1;
            end
            if (i_cmd.cnt_miss && r_misses != '1) begin
                r_misses <= r_misses + 1'b1;
            end
        end
    end

    // Per-word result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_res_fh <= '0;
            r_res_fs <= '0;
            r_evn    <= '0;
        end else begin
            if (i_cmd.evict && r_evn != '1) begin
                r_evn <= r_evn + 1'b1;
            end
            if (i_cmd.cap_found) begin
                r_res_fh <= w_rd_handle;
                r_res_fs <= w_rd_size;
            end
        end
        if (i_cmd.res_we) begin
            r_res_status <= i_cmd.res_status;
        end
    end

    // Output register; it holds a finished word while the next one is worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out_status <= r_res_status;
            r_out_fh     <= r_res_fh;
            r_out_fs     <= r_res_fs;
            r_out_evn    <= r_evn;
            r_out_bytes  <= r_bytes;
            r_out_hits   <= r_hits;
            r_out_misses <= r_misses;
            r_out_evicts <= r_evicts;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_found_handle = r_out_fh;
    assign o_found_size   = r_out_fs;
    assign o_evicted_now  = r_out_evn;
    assign o_bytes_in_use = r_out_bytes;
    assign o_hit_total    = r_out_hits;
    assign o_miss_total   = r_out_misses;
    assign o_evict_total  = r_out_evicts;

endmodule

`default_nettype wire

### design/fifo_cache_byte_budget_top.sv
// FIFO cache directory with a byte budget. Words enter one at a time on the
// request channel; each returns exactly one result word. A lookup passes the match,
// look and done states, plus a hit-read state on a hit: the key is compared against
// all slots in parallel, the match is encoded the next cycle, and a hit reads
// handle and size from the slot memory. An insert adds an evict and a write state
// and stays in evict while entries must go to free bytes, walking the oldest slots
// one per cycle through the single read port of the slot memory; the extra
// eviction that frees a slot in a full table comes as evict passes to write.
// Refused inserts (key already present, or size above the budget) go from look to
// done. A finished result sits in an output register, so a new request is taken
// while it waits. The budget register may be written only while the block is idle.
`default_nettype none

module fifo_cache_byte_budget_top #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fcbb_pkg::WORD_W-1:0]   i_cfg_capacity_bytes,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [fcbb_pkg::KEY_W-1:0]    i_key,
    input  logic [fcbb_pkg::HANDLE_W-1:0] i_object_handle,
    input  logic [fcbb_pkg::SIZE_W-1:0]   i_item_size,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fcbb_pkg::STATUS_W-1:0] o_status,
    output logic [fcbb_pkg::HANDLE_W-1:0] o_found_handle,
    output logic [fcbb_pkg::SIZE_W-1:0]   o_found_size,
    output logic [fcbb_pkg::EVN_W-1:0]    o_evicted_now,
    output logic [fcbb_pkg::WORD_W-1:0]   o_bytes_in_use,
    output logic [fcbb_pkg::WORD_W-1:0]   o_hit_total,
    output logic [fcbb_pkg::WORD_W-1:0]   o_miss_total,
    output logic [fcbb_pkg::WORD_W-1:0]   o_evict_total
);

    import fcbb_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // The budget register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    fcbb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    fcbb_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_capacity_bytes (i_cfg_capacity_bytes),
        .i_req_type           (i_req_type),
        .i_key                (i_key),
        .i_object_handle      (i_object_handle),
        .i_item_size          (i_item_size),
        .i_cmd                (w_cmd),
        .o_stat               (w_stat),
        .i_out_ready          (i_ready),
        .o_valid              (o_valid),
        .o_status             (o_status),
        .o_found_handle       (o_found_handle),
        .o_found_size         (o_found_size),
        .o_evicted_now        (o_evicted_now),
        .o_bytes_in_use       (o_bytes_in_use),
        .o_hit_total          (o_hit_total),
        .o_miss_total         (o_miss_total),
        .o_evict_total        (o_evict_total)
    );

    // A new entry is written only into a table with a free slot.
    a_insert_not_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.insert |-> !w_stat.full)
        else $error("insert into a full table");

    // Eviction only happens while entries are held.
    a_evict_not_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.evict |-> !w_stat.empty)
        else $error("eviction from an empty table");

    // Only one request is in work at a time.
    a_one_in_flight : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while another is in work");

    // A result is loaded only when the output register is free.
    a_load_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ld_out |-> (!o_valid || i_ready))
        else $error("result overwrote an undelivered word");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import fcbb_pkg::*;

    localparam int SLOTS = 64;
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;
    localparam logic [WORD_W-1:0] BUDGET_MAX = '1;
    localparam int POOL_KEYS = 80;

    // One request word and one result word as the ports carry them.
    typedef struct packed {
        logic                req_type;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
    } t_request;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
        logic [EVN_W-1:0]    evicted;
        logic [WORD_W-1:0]   bytes_in_use;
        logic [WORD_W-1:0]   hits;
        logic [WORD_W-1:0]   misses;
        logic [WORD_W-1:0]   evicts;
    } t_result;

    // Size mixes for the random phases.
    typedef enum int {SZ_ANY, SZ_TINY, SZ_MID, SZ_NONE} t_size_mix;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [WORD_W-1:0]   i_cfg_capacity_bytes;
    logic                i_valid;
    logic                o_ready;
    logic                i_req_type;
    logic [KEY_W-1:0]    i_key;
    logic [HANDLE_W-1:0] i_object_handle;
    logic [SIZE_W-1:0]   i_item_size;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [HANDLE_W-1:0] o_found_handle;
    logic [SIZE_W-1:0]   o_found_size;
    logic [EVN_W-1:0]    o_evicted_now;
    logic [WORD_W-1:0]   o_bytes_in_use;
    logic [WORD_W-1:0]   o_hit_total;
    logic [WORD_W-1:0]   o_miss_total;
    logic [WORD_W-1:0]   o_evict_total;

    fifo_cache_byte_budget_top DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_capacity_bytes (i_cfg_capacity_bytes),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_req_type           (i_req_type),
        .i_key                (i_key),
        .i_object_handle      (i_object_handle),
        .i_item_size          (i_item_size),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_status             (o_status),
        .o_found_handle       (o_found_handle),
        .o_found_size         (o_found_size),
        .o_evicted_now        (o_evicted_now),
        .o_bytes_in_use       (o_bytes_in_use),
        .o_hit_total          (o_hit_total),
        .o_miss_total         (o_miss_total),
        .o_evict_total        (o_evict_total)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the cache directory, kept in step with accepted words.
    logic [KEY_W-1:0]    slot_key    [SLOTS];
    logic [HANDLE_W-1:0] slot_handle [SLOTS];
    logic [SIZE_W-1:0]   slot_size   [SLOTS];
    logic                slot_live   [SLOTS] = '{default: 1'b0};
    int unsigned         head_slot  = 0;
    int unsigned         tail_slot  = 0;
    int unsigned         live_count = 0;
    logic [WORD_W-1:0]   bytes_held = '0;
    logic [WORD_W-1:0]   hit_cnt    = '0;
    logic [WORD_W-1:0]   miss_cnt   = '0;
    logic [WORD_W-1:0]   evict_cnt  = '0;
    logic [WORD_W-1:0]   budget     = '0;

    // Traffic bookkeeping shared by the driver, the monitor and the sequencer.
    t_request pending_q [$];
    t_result  expected_q [$];
    int       words_sent   = 0;
    int       words_in     = 0;
    int       words_out    = 0;
    int       mismatches   = 0;
    int       tx_gap       = 0;
    int       rx_gap       = 0;
    int       hold_left    = 0;
    int       next_hold_at = 300;
    logic     tx_idle_on   = 1'b0;
    logic     rx_idle_on   = 1'b0;

    logic [KEY_W-1:0]  key_pool [POOL_KEYS];
    logic [WORD_W-1:0] phase_budget;

    function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Retire the oldest entry of the shadow directory.
    function automatic void drop_oldest();
        logic [SIZE_W-1:0] sz;
        sz = slot_size[tail_slot];
        slot_live[tail_slot] = 1'b0;
        bytes_held = (bytes_held >= sz) ? bytes_held - sz : '0;
        tail_slot = (tail_slot + 1) % SLOTS;
        live_count--;
        evict_cnt = sat_inc(evict_cnt);
    endfunction

    // Apply one request to the shadow directory and return the result it must produce.
    function automatic t_result cache_step(input t_request rq);
        t_result rs;
        int      hit_slot;
        int      i;
        rs = '0;
        hit_slot = -1;
        for (i = 0; i < SLOTS; i++) begin
            if (hit_slot < 0 && slot_live[i] && slot_key[i] == rq.key)
                hit_slot = i;
        end
        if (rq.req_type == REQ_LOOKUP) begin
            if (hit_slot >= 0) begin
                rs.status = ST_HIT;
                rs.handle = slot_handle[hit_slot];
                rs.size   = slot_size[hit_slot];
                hit_cnt   = sat_inc(hit_cnt);
            end else begin
                rs.status = ST_MISS;
                miss_cnt  = sat_inc(miss_cnt);
            end
        end else if (hit_slot >= 0) begin
            rs.status = ST_PRESENT;
        end else if (WORD_W'(rq.size) > budget) begin
            rs.status = ST_TOO_LARGE;
        end else begin
            // Evict oldest entries until the new one fits, then make room in a full table.
            while (live_count > 0 &&
                   ({1'b0, bytes_held} + 33'(rq.size) > {1'b0, budget})) begin
                drop_oldest();
                if (rs.evicted != '1)
                    rs.evicted = rs.evicted + 1'b1;
            end
            if (live_count >= SLOTS) begin
                drop_oldest();
                if (rs.evicted != '1)
                    rs.evicted = rs.evicted + 1'b1;
            end
            slot_key[head_slot]    = rq.key;
            slot_handle[head_slot] = rq.handle;
            slot_size[head_slot]   = rq.size;
            slot_live[head_slot]   = 1'b1;
            head_slot  = (head_slot + 1) % SLOTS;
            live_count++;
            bytes_held = bytes_held + WORD_W'(rq.size);
            rs.status  = ST_INSERTED;
        end
        rs.bytes_in_use = bytes_held;
        rs.hits         = hit_cnt;
        rs.misses       = miss_cnt;
        rs.evicts       = evict_cnt;
        return rs;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[KEY_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size(input t_size_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            SZ_ANY: begin
                if (r < 10)
                    return '0;
                if (r < 20)
                    return '1;
                return SIZE_W'($urandom());
            end
            SZ_TINY: begin
                if (r < 70)
                    return SIZE_W'($urandom_range(0, 2));
                if (r < 92)
                    return SIZE_W'($urandom_range(3, 20));
                if (r < 98)
                    return SIZE_W'(phase_budget);
                return SIZE_W'(phase_budget) + SIZE_W'($urandom_range(1, 100));
            end
            SZ_MID: begin
                if (r < 90)
                    return SIZE_W'($urandom_range(0, phase_budget / 3));
                if (r < 95)
                    return SIZE_W'(phase_budget);
                return SIZE_W'(phase_budget)
                       + SIZE_W'($urandom_range(1, 3 * phase_budget));
            end
            default: begin
                if (r < 85)
                    return '0;
                return SIZE_W'($urandom_range(1, 24'hFFFFFF));
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb: result %0d field %s: expected %h, got %h",
                         words_out, name, want, got);
        end
    endtask

    // Request driver: offers queued words, with random gaps between them.
    always @(negedge i_clk) begin : req_driver
        t_request rq;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (words_in == words_sent) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                rq = pending_q.pop_front();
                i_req_type      <= rq.req_type;
                i_key           <= rq.key;
                i_object_handle <= rq.handle;
                i_item_size     <= rq.size;
                i_valid         <= 1'b1;
                words_sent++;
                tx_gap = tx_idle_on ? idle_len() : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started every few hundred results.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (words_out >= next_hold_at) begin
            hold_left    <= $urandom_range(150, 300);
            next_hold_at <= next_hold_at + 600;
        end
    end

    // Result receiver: ready with random stalls, low during a hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_left != 0) begin
            i_ready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (rx_idle_on)
                rx_gap = idle_len();
        end
    end

    // Monitor: checks each result word, then predicts for each accepted request word.
    always @(posedge i_clk) begin : result_mon
        t_result  want;
        t_request rq;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                words_out++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: result %0d arrived with nothing expected", words_out);
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", 64'(want.status), 64'(o_status));
                    check_field("found_handle", want.handle, o_found_handle);
                    check_field("found_size", 64'(want.size), 64'(o_found_size));
                    check_field("evicted_now", 64'(want.evicted), 64'(o_evicted_now));
                    check_field("bytes_in_use", 64'(want.bytes_in_use),
                                64'(o_bytes_in_use));
                    check_field("hit_total", 64'(want.hits), 64'(o_hit_total));
                    check_field("miss_total", 64'(want.misses), 64'(o_miss_total));
                    check_field("evict_total", 64'(want.evicts), 64'(o_evict_total));
                end
            end
            if (i_valid && o_ready) begin
                rq.req_type = i_req_type;
                rq.key      = i_key;
                rq.handle   = i_object_handle;
                rq.size     = i_item_size;
                want        = cache_step(rq);
                expected_q  = {expected_q, want};
                words_in++;
            end
        end
    end

    task automatic push_req(input logic rt, input logic [KEY_W-1:0] k,
                            input logic [HANDLE_W-1:0] h, input logic [SIZE_W-1:0] s);
        t_request rq;
        rq.req_type = rt;
        rq.key      = k;
        rq.handle   = h;
        rq.size     = s;
        pending_q = {pending_q, rq};
    endtask

    // Wait until every queued word is taken and every result has come back.
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (pending_q.size() != 0 || words_in != words_sent || expected_q.size() != 0);
    endtask

    task automatic write_budget(input logic [WORD_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid          <= 1'b1;
        i_cfg_capacity_bytes <= v;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        budget = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One random phase: a fresh key pool, mostly reused keys, a mix of inserts and lookups.
    task automatic run_phase(input logic [WORD_W-1:0] cap, input t_size_mix mix,
                             input int count, input logic tx_on, input logic rx_on);
        int n;
        int r;
        logic [KEY_W-1:0] k;
        write_budget(cap);
        phase_budget = cap;
        tx_idle_on   = tx_on;
        rx_idle_on   = rx_on;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < POOL_KEYS; n++)
            key_pool[n] = rand_key();
        for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, POOL_KEYS - 1)]
                                             : rand_key();
            push_req((r < 45) ? REQ_INSERT : REQ_LOOKUP, k, {$urandom(), $urandom()},
                     pick_size(mix));
        end
        wait_drained();
    endtask

    // Reset, directed cases, random phases, then the verdict.
    initial begin
        i_rst_n              = 1'b0;
        i_cfg_valid          = 1'b0;
        i_cfg_capacity_bytes = '0;
        i_valid              = 1'b0;
        i_req_type           = REQ_LOOKUP;
        i_key                = '0;
        i_object_handle      = '0;
        i_item_size          = '0;
        i_ready              = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Budget at its reset value of zero: only zero-size entries fit.
        push_req(REQ_INSERT, 48'h0, 64'h0, 24'd0);
        push_req(REQ_INSERT, 48'h1, 64'h1111, 24'd1);
        push_req(REQ_LOOKUP, 48'h0, 64'h0, 24'd0);
        push_req(REQ_INSERT, 48'h0, 64'h2222, 24'd0);
        push_req(REQ_LOOKUP, 48'h1, 64'h0, 24'd0);
        wait_drained();

        // Byte budget forces oldest-first eviction, and an item as large as the budget.
        write_budget(32'd1000);
        push_req(REQ_INSERT, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 24'd400);
        push_req(REQ_INSERT, 48'h0000_0000_00B0, 64'h5A5A_5A5A_5A5A_5A5A, 24'd400);
        push_req(REQ_INSERT, 48'h0000_0000_00C0, 64'hA5A5_A5A5_A5A5_A5A5, 24'd300);
        push_req(REQ_LOOKUP, 48'hFFFF_FFFF_FFFF, 64'h0, 24'd0);
        push_req(REQ_LOOKUP, 48'h0000_0000_00B0, 64'h0, 24'd0);
        push_req(REQ_INSERT, 48'h0000_0000_00D0, 64'h0123_4567_89AB_CDEF, 24'd1000);
        push_req(REQ_INSERT, 48'h0000_0000_00E0, 64'h1, 24'hFF_FFFF);
        push_req(REQ_LOOKUP, 48'h0000_0000_00D0, 64'h0, 24'd0);
        wait_drained();

        // Budget lowered under a full entry: lookups still hit, the next insert evicts.
        write_budget(32'd50);
        push_req(REQ_LOOKUP, 48'h0000_0000_00D0, 64'h0, 24'd0);
        push_req(REQ_INSERT, 48'h0000_0000_00F0, 64'hDEAD_0000_0000_BEEF, 24'd10);
        push_req(REQ_INSERT, 48'h8000_0000_0000, 64'h8000_0000_0000_0000, 24'd40);
        push_req(REQ_INSERT, 48'h7FFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 24'd0);
        push_req(REQ_LOOKUP, 48'h8000_0000_0000, 64'h0, 24'd0);
        wait_drained();

        // Largest budget with largest items.
        write_budget(BUDGET_MAX);
        push_req(REQ_INSERT, 48'h1234_5678_9ABC, 64'hFEDC_BA98_7654_3210, 24'hFF_FFFF);
        push_req(REQ_INSERT, 48'hABCD_EF01_2345, 64'h0F0F_0F0F_F0F0_F0F0, 24'hFF_FFFF);
        push_req(REQ_LOOKUP, 48'h1234_5678_9ABC, 64'h0, 24'd0);
        push_req(REQ_LOOKUP, 48'h5555_AAAA_5555, 64'h0, 24'd0);
        push_req(REQ_INSERT, 48'hABCD_EF01_2345, 64'h3, 24'd5);
        wait_drained();

        // Random phases over several budgets, with and without idling.
        run_phase(BUDGET_MAX, SZ_ANY, 400, 1'b1, 1'b1);
        run_phase(32'd64, SZ_TINY, 400, 1'b0, 1'b0);
        run_phase(32'd5000, SZ_MID, 350, 1'b1, 1'b0);
        run_phase(32'd0, SZ_NONE, 300, 1'b0, 1'b1);
        run_phase(BUDGET_MAX, SZ_ANY, 350, 1'b1, 1'b1);

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #30_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
